/* src/ght_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ght_pkg
// Shared types, widths and helpers for the generational handle table.
// ----------------------------------------------------------------------------
package ght_pkg;

    localparam int SLOTS    = 64;
    localparam int IDX_W    = $clog2(SLOTS);
    localparam int INDEX_W  = 6;
    localparam int GEN_W    = 32;
    localparam int DATA_W   = 64;
    localparam int CNT_W    = $clog2(SLOTS + 1);
    localparam int CMP_W    = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

    localparam logic [GEN_W-1:0] GEN_RESET = GEN_W'(1);

    typedef enum logic [1:0] {
        OP_ALLOC       = 2'd0,
        OP_RELEASE     = 2'd1,
        OP_LOOKUP      = 2'd2,
        OP_RELEASE_ALL = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_STALE       = 2'd1,
        ST_BAD_BACKEND = 2'd2,
        ST_FULL        = 2'd3
    } status_t;

    // Stored contents of one slot besides its generation.
    typedef struct packed {
        logic [DATA_W-1:0] backend;
        logic [DATA_W-1:0] entity_low;
        logic [DATA_W-1:0] entity_high;
    } payload_t;

    // Lowest free slot search result.
    typedef struct packed {
        logic             full;
        logic [IDX_W-1:0] idx;
    } free_t;

    // Next generation, skipping zero on wrap.
    function automatic logic [GEN_W-1:0] advance_gen(input logic [GEN_W-1:0] g);
        logic [GEN_W-1:0] n;
        n = g + GEN_W'(1);
        return (n == '0) ? GEN_RESET : n;
    endfunction

endpackage
`default_nettype wire

/* src/ght_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ght_if
// Request and response channels of the generational handle table.
// ----------------------------------------------------------------------------
interface ght_req_if import ght_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [1:0]          op;
    logic [INDEX_W-1:0]  slot_index;
    logic [GEN_W-1:0]    handle_generation;
    logic [DATA_W-1:0]   backend_handle;
    logic [DATA_W-1:0]   entity_low;
    logic [DATA_W-1:0]   entity_high;

    modport source (
        output valid, op, slot_index, handle_generation,
               backend_handle, entity_low, entity_high,
        input  ready
    );
    modport sink (
        input  valid, op, slot_index, handle_generation,
               backend_handle, entity_low, entity_high,
        output ready
    );
endinterface

interface ght_rsp_if import ght_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [1:0]          status;
    logic [INDEX_W-1:0]  out_index;
    logic [GEN_W-1:0]    out_generation;
    logic [DATA_W-1:0]   stored_backend;
    logic [DATA_W-1:0]   stored_entity_low;
    logic [DATA_W-1:0]   stored_entity_high;
    logic                any_active;

    modport source (
        output valid, status, out_index, out_generation, stored_backend,
               stored_entity_low, stored_entity_high, any_active,
        input  ready
    );
    modport sink (
        input  valid, status, out_index, out_generation, stored_backend,
               stored_entity_low, stored_entity_high, any_active,
        output ready
    );
endinterface
`default_nettype wire

/* src/generational_handle_table.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// generational_handle_table
// Slot table handing out (index, generation) handles with lookup and release.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                        | transfer
//  --------+-----+------------------------------------------------+----------------
//  req     | in  | op, slot_index, handle_generation,             | valid && ready
//          |     | backend_handle, entity_low, entity_high        |
//  rsp     | out | status, out_index, out_generation,             | valid && ready
//          |     | stored_backend, stored_entity_low/high,        |
//          |     | any_active                                     |
//
// One request per cycle unless a stalled response holds the input stage. A
// request is registered in the input stage (where its slot's generation and
// payload are read from the slot memories) and then resolved into the response register.
// Reset takes effect at once: active, pending-advance and generation-valid
// bits are flip-flops, so no clearing pass is needed. A stalled response
// holds the input stage, and req.ready falls only when both stages are full.
// ----------------------------------------------------------------------------
module generational_handle_table import ght_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    ght_req_if.sink    req,
    ght_rsp_if.source  rsp
);

    // ------------------------------------------------------------------
    // Per-slot flag state. A slot whose generation was never written reads
    // as GEN_RESET. Release-all does not touch the generation memory: it
    // marks each freed slot with a pending advance, applied on next use.
    // ------------------------------------------------------------------
    logic [SLOTS-1:0] active_reg,    active_next;
    logic [SLOTS-1:0] gen_valid_reg, gen_valid_next;
    logic [SLOTS-1:0] bump_reg,      bump_next;

    // slot memories
    logic [GEN_W-1:0] gen_mem [SLOTS];
    payload_t         pay_mem [SLOTS];

    // input stage
    logic             s1_valid_reg;
    op_t              s1_op_reg;
    logic [GEN_W-1:0] s1_gen_reg;
    logic             s1_idx_ok_reg;
    logic [IDX_W-1:0] s1_addr_reg;
    logic             s1_full_reg;
    payload_t         s1_pay_reg;
    logic [GEN_W-1:0] gen_rd_reg;
    payload_t         pay_rd_reg;

    // response register
    logic               out_valid_reg;
    status_t            status_reg,     status_next;
    logic [INDEX_W-1:0] out_index_reg,  out_index_next;
    logic [GEN_W-1:0]   out_gen_reg,    out_gen_next;
    payload_t           out_pay_reg,    out_pay_next;
    logic               any_active_reg;

    // handshake
    logic req_fire;
    logic advance;

    // resolve logic
    logic [GEN_W-1:0] gen_cur;
    logic [GEN_W-1:0] gen_eff;
    logic             live;
    logic             gen_we;
    logic [GEN_W-1:0] gen_wdata;
    logic             pay_we;

    // read side for the incoming request
    op_t              req_op;
    free_t            free_slot;
    logic [IDX_W-1:0] rd_addr;
    logic             idx_ok;

    // ------------------------------------------------------------------
    // Handshake: advance the input stage when the response slot is free
    // or being drained this cycle.
    // ------------------------------------------------------------------
    assign advance   = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || advance;
    assign req_fire  = req.valid && req.ready;

    // ------------------------------------------------------------------
    // Resolve the item in the input stage.
    // ------------------------------------------------------------------
    assign gen_cur = gen_valid_reg[s1_addr_reg] ? gen_rd_reg : GEN_RESET;
    assign gen_eff = bump_reg[s1_addr_reg] ? advance_gen(gen_cur) : gen_cur;
    assign live    = s1_idx_ok_reg && active_reg[s1_addr_reg] && (gen_eff == s1_gen_reg);

    always_comb
    begin
        active_next    = active_reg;
        gen_valid_next = gen_valid_reg;
        bump_next      = bump_reg;
        gen_we         = 1'b0;
        gen_wdata      = gen_eff;
        pay_we         = 1'b0;
        status_next    = ST_OK;
        out_index_next = '0;
        out_gen_next   = '0;
        out_pay_next   = '0;

        if (advance)
        begin
            case (s1_op_reg)
                OP_ALLOC:
                begin
                    if (s1_pay_reg.backend == '0)
                    begin
                        status_next = ST_BAD_BACKEND;
                    end
                    else if (s1_full_reg)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        // commit any pending advance along with the new contents
                        active_next[s1_addr_reg]    = 1'b1;
                        gen_valid_next[s1_addr_reg] = 1'b1;
                        bump_next[s1_addr_reg]      = 1'b0;
                        gen_we                      = 1'b1;
                        gen_wdata                   = gen_eff;
                        pay_we                      = 1'b1;
                        out_index_next              = INDEX_W'(s1_addr_reg);
                        out_gen_next                = gen_eff;
                    end
                end
                OP_RELEASE:
                begin
                    if (live)
                    begin
                        active_next[s1_addr_reg]    = 1'b0;
                        gen_valid_next[s1_addr_reg] = 1'b1;
                        bump_next[s1_addr_reg]      = 1'b0;
                        gen_we                      = 1'b1;
                        gen_wdata                   = advance_gen(gen_eff);
                    end
                    else
                    begin
                        status_next = ST_STALE;
                    end
                end
                OP_LOOKUP:
                begin
                    if (live)
                    begin
                        out_pay_next = pay_rd_reg;
                    end
                    else
                    begin
                        status_next = ST_STALE;
                    end
                end
                OP_RELEASE_ALL:
                begin
                    // defer each freed slot's generation advance
                    bump_next   = bump_reg | active_reg;
                    active_next = '0;
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Read side: address the memories for the incoming request, seeing the
    // flag state as it will be after the item now resolving.
    // ------------------------------------------------------------------
    assign req_op = op_t'(req.op);

    ght_free_finder u_free_finder
    (
        .busy   (active_next),
        .result (free_slot)
    );

    assign idx_ok  = (req.slot_index != '0) &&
                     (CMP_W'(req.slot_index) < CMP_W'(SLOTS));
    assign rd_addr = (req_op == OP_ALLOC) ? free_slot.idx : IDX_W'(req.slot_index);

    // ------------------------------------------------------------------
    // Slot memories: one write port (resolving item), one registered read
    // port (incoming item); bypass a same-address write.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (gen_we)
        begin
            gen_mem[s1_addr_reg] <= gen_wdata;
        end
        if (req_fire)
        begin
            if (gen_we && (s1_addr_reg == rd_addr))
            begin
                gen_rd_reg <= gen_wdata;
            end
            else
            begin
                gen_rd_reg <= gen_mem[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pay_we)
        begin
            pay_mem[s1_addr_reg] <= s1_pay_reg;
        end
        if (req_fire)
        begin
            if (pay_we && (s1_addr_reg == rd_addr))
            begin
                pay_rd_reg <= s1_pay_reg;
            end
            else
            begin
                pay_rd_reg <= pay_mem[rd_addr];
            end
        end
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= '0;
            gen_valid_reg <= '0;
            bump_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            gen_valid_reg <= gen_valid_next;
            bump_reg      <= bump_next;
            if (req_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers: load input stage on transfer, response on advance.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            s1_op_reg              <= req_op;
            s1_gen_reg             <= req.handle_generation;
            s1_idx_ok_reg          <= idx_ok;
            s1_addr_reg            <= rd_addr;
            s1_full_reg            <= free_slot.full;
            s1_pay_reg.backend     <= req.backend_handle;
            s1_pay_reg.entity_low  <= req.entity_low;
            s1_pay_reg.entity_high <= req.entity_high;
        end
        if (advance)
        begin
            status_reg     <= status_next;
            out_index_reg  <= out_index_next;
            out_gen_reg    <= out_gen_next;
            out_pay_reg    <= out_pay_next;
            any_active_reg <= |active_next[SLOTS-1:1];
        end
    end

    assign rsp.valid              = out_valid_reg;
    assign rsp.status             = status_reg;
    assign rsp.out_index          = out_index_reg;
    assign rsp.out_generation     = out_gen_reg;
    assign rsp.stored_backend     = out_pay_reg.backend;
    assign rsp.stored_entity_low  = out_pay_reg.entity_low;
    assign rsp.stored_entity_high = out_pay_reg.entity_high;
    assign rsp.any_active         = any_active_reg;

endmodule
`default_nettype wire

/* src/ght_free_finder.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ght_free_finder
// Priority encoder: lowest inactive slot above the reserved slot 0.
// ----------------------------------------------------------------------------
module ght_free_finder import ght_pkg::*;
(
    input  wire logic [SLOTS-1:0] busy,
    output free_t                 result
);

    always_comb
    begin
        result.full = 1'b1;
        result.idx  = '0;
        // scan downward so the lowest free slot wins
        for (int i = SLOTS - 1; i >= 1; i--)
        begin
            if (!busy[i])
            begin
                result.full = 1'b0;
                result.idx  = IDX_W'(i);
            end
        end
    end

endmodule
`default_nettype wire
